[src/sha256_stream_hasher_core_macros.svh]
// Assertion macros for the SHA-256 stream hasher checker.
// No dependencies.
`ifndef SHA256_STREAM_HASHER_CORE_MACROS_SVH
`define SHA256_STREAM_HASHER_CORE_MACROS_SVH
// Assert a property on the rising clock, skipped while reset is low.
`define SHA_ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert a property checked during reset too.
`define SHA_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`endif

[src/sha_pkg.sv]
// Package for the SHA-256 stream hasher: types, round constants, initial hash values, rotate function.
// No dependencies.
`timescale 1ns / 1ps

package sha_pkg;

    localparam int unsigned FifoDepth = 4;
    localparam logic [7:0] PadByte = 8'h80;

    typedef logic [31:0] t_word;

    // Entry that the front hands to the back.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } t_state;

    // Back part status shared with the top level.
    typedef struct packed {
        logic busy;
        logic emitting;
    } t_back_status;

    function automatic t_word round_k(input logic [5:0] t);
        t_word k;
        case (t)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_word initial_h(input logic [2:0] i);
        t_word h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic t_word rotr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

endpackage

[src/sha_front.sv]
// Front part: input queue of accepted items ahead of the compression engine.
// Depends on sha_pkg.
`timescale 1ns / 1ps

module sha_front #(
    parameter int unsigned DEPTH = sha_pkg::FifoDepth
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sha_pkg::t_item i_item,
    output logic          o_full,
    output logic          o_valid,
    output sha_pkg::t_item o_item,
    input  logic          i_take
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [AW:0]   r_cnt;
    logic do_push, do_pop;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(do_push) - (AW+1)'(do_pop);
        end
    end
endmodule

[src/sha_back.sv]
// Back part: block gathering, padding, 64-round compression and digest output.
// Depends on sha_pkg.
`timescale 1ns / 1ps

module sha_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  sha_pkg::t_item       i_item,
    output logic                 o_take,
    output logic                 o_out_valid,
    output logic [31:0]          o_word,
    output logic [2:0]           o_num,
    output logic                 o_last,
    input  logic                 i_out_pop,
    output sha_pkg::t_back_status o_status
);
    sha_pkg::t_state r_state, n_state;

    logic [31:0] r_w [16];     // message schedule window, w[t] at index 0
    logic [31:0] r_h [8];
    logic [31:0] r_v [8];
    logic [5:0]  r_fill;       // bytes in the current block
    logic [63:0] r_bits;
    logic [5:0]  r_t;
    logic [2:0]  r_k;
    logic        r_pad;        // padding in progress
    logic        r_len_done;   // length placed in this block, emit after it
    logic        r_pad_flag;   // 0x80 already placed

    // schedule and round terms
    logic [31:0] s0, s1, w_new, big0, big1, ch, maj, t1, t2;
    always_comb begin
        s0 = sha_pkg::rotr(r_w[1], 7) ^ sha_pkg::rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = sha_pkg::rotr(r_w[14], 17) ^ sha_pkg::rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        big1 = sha_pkg::rotr(r_v[4], 6) ^ sha_pkg::rotr(r_v[4], 11)
             ^ sha_pkg::rotr(r_v[4], 25);
        ch   = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
        t1   = r_v[7] + big1 + ch + sha_pkg::round_k(r_t) + r_w[0];
        big0 = sha_pkg::rotr(r_v[0], 2) ^ sha_pkg::rotr(r_v[0], 13)
             ^ sha_pkg::rotr(r_v[0], 22);
        maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
        t2   = big0 + maj;
    end

    // length may go into this block only if 0x80 landed at or before byte 55
    logic r_len_ok;

    // padding byte for the current fill position
    logic [7:0] pad_byte;
    logic [5:0] len_idx;
    always_comb begin
        len_idx = r_fill - 6'd56;
        if (r_fill >= 6'd56 && !(r_fill == 6'd56 && !r_pad_flag) && r_pad_flag
            && r_len_ok) begin
            pad_byte = r_bits[8'(7 - len_idx[2:0]) * 8 +: 8];
        end else if (!r_pad_flag) begin
            pad_byte = sha_pkg::PadByte;
        end else begin
            pad_byte = 8'h00;
        end
    end

    // select the byte written into the schedule window (bytes arrive big-endian)
    logic [7:0] in_byte;
    logic       load_byte;
    always_comb begin
        in_byte = (r_state == sha_pkg::ST_LOAD) ? pad_byte : i_item.data_byte;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sha_pkg::ST_IDLE: begin
                if (i_valid) begin
                    if (i_item.byte_present && r_fill == 6'd63) begin
                        n_state = sha_pkg::ST_ROUND;
                    end else if (i_item.end_of_message) begin
                        n_state = sha_pkg::ST_LOAD;
                    end
                end
            end
            sha_pkg::ST_LOAD: begin
                if (r_fill == 6'd63) begin
                    n_state = sha_pkg::ST_ROUND;
                end
            end
            sha_pkg::ST_ROUND: begin
                if (r_t == 6'd63) begin
                    n_state = sha_pkg::ST_ADD;
                end
            end
            sha_pkg::ST_ADD: begin
                if (r_len_done) begin
                    n_state = sha_pkg::ST_EMIT;
                end else if (r_pad) begin
                    n_state = sha_pkg::ST_LOAD;
                end else begin
                    n_state = sha_pkg::ST_IDLE;
                end
            end
            sha_pkg::ST_EMIT: begin
                if (i_out_pop && r_k == 3'd7) begin
                    n_state = sha_pkg::ST_IDLE;
                end
            end
            default: n_state = sha_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_take      = (r_state == sha_pkg::ST_IDLE);
        o_out_valid = (r_state == sha_pkg::ST_EMIT);
        o_word      = r_h[r_k];
        o_num       = r_k;
        o_last      = (r_k == 3'd7);
        o_status.busy     = (r_state != sha_pkg::ST_IDLE);
        o_status.emitting = o_out_valid;
        load_byte = ((r_state == sha_pkg::ST_IDLE) && i_valid && i_item.byte_present)
                  || (r_state == sha_pkg::ST_LOAD);
    end

    always_ff @(posedge i_clk) begin
        if (load_byte) begin
            r_w[r_fill[5:2]][8'(3 - r_fill[1:0]) * 8 +: 8] <= in_byte;
        end
        if (r_state == sha_pkg::ST_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i+1];
            end
            r_w[15] <= w_new;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end else begin
            for (int i = 0; i < 8; i++) begin
                r_v[i] <= r_h[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha_pkg::ST_IDLE;
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha_pkg::initial_h(3'(i));
            end
            r_fill <= '0;
            r_bits <= '0;
            r_t <= '0;
            r_k <= '0;
            r_pad <= 1'b0;
            r_len_done <= 1'b0;
            r_pad_flag <= 1'b0;
            r_len_ok <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_byte) begin
                r_fill <= r_fill + 6'd1;
            end
            case (r_state)
                sha_pkg::ST_IDLE: begin
                    if (i_valid) begin
                        if (i_item.byte_present) begin
                            r_bits <= r_bits + 64'd8;
                        end
                        r_pad <= i_item.end_of_message;
                        // 0x80 goes after the optional byte; length fits if at most 55 then
                        r_len_ok <= ((i_item.byte_present ? r_fill + 6'd1 : r_fill) < 6'd56)
                                  && !(i_item.byte_present && r_fill == 6'd63);
                    end
                end
                sha_pkg::ST_LOAD: begin
                    r_pad_flag <= 1'b1;
                    if (r_fill == 6'd63) begin
                        r_len_done <= r_len_ok;
                    end
                end
                sha_pkg::ST_ROUND: begin
                    r_t <= r_t + 6'd1;
                end
                sha_pkg::ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_h[i] <= r_h[i] + r_v[i];
                    end
                    // next pass of padding: length always fits a fresh block
                    r_len_ok <= 1'b1;
                end
                sha_pkg::ST_EMIT: begin
                    if (i_out_pop) begin
                        r_k <= r_k + 3'd1;
                        if (r_k == 3'd7) begin
                            for (int i = 0; i < 8; i++) begin
                                r_h[i] <= sha_pkg::initial_h(3'(i));
                            end
                            r_bits <= '0;
                            r_pad <= 1'b0;
                            r_len_done <= 1'b0;
                            r_pad_flag <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end
endmodule

[src/sha256_stream_hasher_core.sv]
// SHA-256 stream hasher: bytes in, eight digest words out per message.
// Throughput: one byte per cycle within a block while items are queued; each full
// block then holds the engine for the take of the last byte, 64 rounds in one shared
// round unit, and the final add.
// Reset: synchronous active-low i_rst_n clears queue, counters and restores initial hash.
`timescale 1ns / 1ps

module sha256_stream_hasher_core #(
    parameter int unsigned FIFO_DEPTH = sha_pkg::FifoDepth
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_number,
    output logic        o_last_word
);
    sha_pkg::t_item       in_item, q_item;
    logic                 q_valid, q_take, out_valid;
    sha_pkg::t_back_status back_status;

    // bundle the item fields for the queue
    assign in_item.data_byte      = i_data_byte;
    assign in_item.byte_present   = i_byte_present;
    assign in_item.end_of_message = i_end_of_message;

    // front: hold accepted items so the input side can stall independently
    sha_front #(.DEPTH(FIFO_DEPTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (in_item),
        .o_full  (full),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_take  (q_take)
    );

    // back: gather bytes, compress, pad, and present digest words for transfer
    sha_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (q_valid),
        .i_item      (q_item),
        .o_take      (q_take),
        .o_out_valid (out_valid),
        .o_word      (o_digest_word),
        .o_num       (o_word_number),
        .o_last      (o_last_word),
        .i_out_pop   (pop),
        .o_status    (back_status)
    );

    assign empty = !(out_valid && back_status.emitting);
endmodule

[src/sha_checker.sv]
// Port-level checker for the SHA-256 stream hasher, bound to the top level.
// Depends on sha256_stream_hasher_core_macros.svh.
`timescale 1ns / 1ps
`include "sha256_stream_hasher_core_macros.svh"

module sha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [2:0]  o_word_number,
    input logic        o_last_word,
    input logic [31:0] o_digest_word
);
    `SHA_ASSERT_CLK(a_last_pos, i_clk, i_rst_n, !empty |-> (o_last_word == (o_word_number == 3'd7)), "last flag wrong")
    `SHA_ASSERT_CLK(a_advance, i_clk, i_rst_n, (!empty && pop && o_word_number != 3'd7) |=> (!empty && o_word_number == $past(o_word_number) + 3'd1), "word sequence broken")
    `SHA_ASSERT_CLK(a_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_digest_word)), "stalled word changed")
    `SHA_ASSERT_ALL(a_reset, i_clk, !i_rst_n |=> empty, "output not empty after reset")
endmodule

bind sha256_stream_hasher_core sha_checker u_sha_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .empty         (empty),
    .pop           (pop),
    .o_word_number (o_word_number),
    .o_last_word   (o_last_word),
    .o_digest_word (o_digest_word)
);
